// File: sv/voxel_run_length_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel run decoder
// Implication checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VOXEL_RUN_LENGTH_DECODER_ASSERT_SVH
`define VOXEL_RUN_LENGTH_DECODER_ASSERT_SVH

// same-cycle implication
`define VRLD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VRLD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/vrld_pkg.sv
// ----------------------------------------------------------------------------
// vrld_pkg
// Types, codes and widths shared by the voxel run decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vrld_pkg;

	localparam int DIM_W        = 13;
	localparam int DIM_MAX_CODE = (1 << DIM_W) - 1;
	localparam int POS_W        = 12;
	localparam int VOL_W        = 3 * DIM_W;
	localparam int BURST_W      = 7;
	localparam int COLOR_W      = 32;
	localparam int COUNT_W      = 8;
	localparam int KIND_W       = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOXEL_COLOR = 3'd4;

	localparam logic [BURST_W-1:0] BURST_RESET = 7'd64;

	localparam logic [KIND_W-1:0] KIND_VOXEL  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_END    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BEYOND = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BADVAL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BUSY   = 3'd4;

	localparam logic CMD_PAIR     = 1'b0;
	localparam logic CMD_CONTINUE = 1'b1;

	localparam logic [COUNT_W-1:0] VALUE_EMPTY  = 8'd0;
	localparam logic [COUNT_W-1:0] VALUE_FILLED = 8'd1;

	typedef struct packed {
		logic               command;
		logic [COUNT_W-1:0] run_value;
		logic [COUNT_W-1:0] run_count;
	} pair_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [POS_W-1:0]   pos_z;
		logic [COLOR_W-1:0] color;
		logic               last;
		logic [COUNT_W-1:0] remaining;
	} voxel_item_t;

	typedef enum logic [1:0] {
		DEC_NONE  = 2'd0,
		DEC_BURST = 2'd1,
		DEC_SKIP  = 2'd2,
		DEC_FAULT = 2'd3
	} dec_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic emit_voxel;
		logic emit_fault;
		logic step_skip;
	} ctrl_cmd_t;

	typedef struct packed {
		dec_t decision;
		logic out_free;
		logic cnt_one;
	} dp_status_t;

endpackage

`default_nettype wire

// File: sv/vrld_if.sv
// ----------------------------------------------------------------------------
// vrld_pair_if / vrld_voxel_if
// Valid/ready channels for run pairs in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrld_pair_if;
	import vrld_pkg::*;
	logic       valid;
	logic       ready;
	pair_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vrld_voxel_if;
	import vrld_pkg::*;
	logic        valid;
	logic        ready;
	voxel_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/vrld_ctrl.sv
// ----------------------------------------------------------------------------
// vrld_ctrl
// Sequencer: takes a pair, waits out the volume product, then runs the
// burst, skip or fault step on the datapath, or returns idle on a no-op.
// ----------------------------------------------------------------------------
`default_nettype none

module vrld_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pair_valid,
	output logic                     pair_ready,
	input  wire vrld_pkg::dp_status_t status,
	output vrld_pkg::ctrl_cmd_t      cmd
);
	import vrld_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL1  = 7'b0000010,
		ST_MUL2  = 7'b0000100,
		ST_EVAL  = 7'b0001000,
		ST_BURST = 7'b0010000,
		ST_SKIP  = 7'b0100000,
		ST_FAULT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		pair_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pair_ready = 1'b1;
				if (pair_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_EVAL;
			ST_EVAL: begin
				cmd.eval = 1'b1;
				case (status.decision)
					DEC_BURST: state_d = ST_BURST;
					DEC_SKIP:  state_d = ST_SKIP;
					DEC_FAULT: state_d = ST_FAULT;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_BURST: begin
				if (status.out_free) begin
					cmd.emit_voxel = 1'b1;
					if (status.cnt_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SKIP: begin
				cmd.step_skip = 1'b1;
				if (status.cnt_one) begin
					state_d = ST_IDLE;
				end
			end
			ST_FAULT: begin
				if (status.out_free) begin
					cmd.emit_fault = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/vrld_dp.sv
// ----------------------------------------------------------------------------
// vrld_dp
// Registers, volume product, cell counters, run checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vrld_dp #(
	parameter int unsigned MAX_DIM   = 4096,
	parameter int unsigned MAX_BURST = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [vrld_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [vrld_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wire vrld_pkg::pair_item_t              pair_data,
	input  wire vrld_pkg::ctrl_cmd_t               cmd,
	output vrld_pkg::dp_status_t                   status,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output vrld_pkg::voxel_item_t                  out_data
);
	import vrld_pkg::*;

	localparam int unsigned DIM_CAP = (MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM;
	localparam logic [DIM_W-1:0]   DIM_CAP_V   = DIM_CAP[DIM_W-1:0];
	localparam logic [BURST_W-1:0] BURST_CAP_V = MAX_BURST[BURST_W-1:0];

	logic [DIM_W-1:0]     size_x_q, size_y_q, size_z_q;
	logic [BURST_W-1:0]   burst_q;
	logic [COLOR_W-1:0]   color_q;

	logic                 command_q;
	logic [COUNT_W-1:0]   value_q, count_q;

	logic [2*DIM_W-1:0]   xy_s1;
	logic [VOL_W-1:0]     vol_s2;

	logic [VOL_W-1:0]     cell_q;
	logic [DIM_W-1:0]     cur_x_q, cur_y_q, cur_z_q;
	logic [COUNT_W-1:0]   pending_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [KIND_W-1:0]    fault_kind_q;
	logic                 out_valid_q;
	voxel_item_t          out_data_q;

	logic [DIM_W-1:0]     eff_x, eff_y, eff_z;
	logic [BURST_W-1:0]   eff_burst;
	logic [VOL_W:0]       run_end;
	logic [COUNT_W-1:0]   need, take;
	dec_t                 decision;
	logic [KIND_W-1:0]    fault_kind;
	logic [DIM_W-1:0]     y_inc, z_inc;
	logic                 advance;
	logic                 out_free;

	assign eff_x = (size_x_q > DIM_CAP_V) ? DIM_CAP_V : size_x_q;
	assign eff_y = (size_y_q > DIM_CAP_V) ? DIM_CAP_V : size_y_q;
	assign eff_z = (size_z_q > DIM_CAP_V) ? DIM_CAP_V : size_z_q;

	always_comb begin
		if (burst_q == '0) begin
			eff_burst = BURST_W'(1);
		end else if (burst_q > BURST_CAP_V) begin
			eff_burst = BURST_CAP_V;
		end else begin
			eff_burst = burst_q;
		end
	end

	assign need    = (command_q == CMD_CONTINUE) ? pending_q : count_q;
	assign take    = (need < {1'b0, eff_burst}) ? need : {1'b0, eff_burst};
	assign run_end = {1'b0, cell_q} + (VOL_W + 1)'(count_q);

	always_comb begin
		decision   = DEC_NONE;
		fault_kind = KIND_BADVAL;
		if (command_q == CMD_CONTINUE) begin
			decision = (pending_q == '0) ? DEC_NONE : DEC_BURST;
		end else if (pending_q != '0) begin
			decision   = DEC_FAULT;
			fault_kind = KIND_BUSY;
		end else if (cell_q >= vol_s2) begin
			decision   = DEC_FAULT;
			fault_kind = KIND_END;
		end else if (run_end > {1'b0, vol_s2}) begin
			decision   = DEC_FAULT;
			fault_kind = KIND_BEYOND;
		end else if (value_q == VALUE_EMPTY) begin
			decision = (count_q == '0) ? DEC_NONE : DEC_SKIP;
		end else if (value_q == VALUE_FILLED) begin
			decision = (count_q == '0) ? DEC_NONE : DEC_BURST;
		end else begin
			decision = DEC_FAULT;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign advance  = cmd.emit_voxel || cmd.step_skip;
	assign y_inc    = cur_y_q + DIM_W'(1);
	assign z_inc    = cur_z_q + DIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= '0;
			size_y_q <= '0;
			size_z_q <= '0;
			burst_q  <= BURST_RESET;
			color_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SIZE_X:      size_x_q <= wr_data[DIM_W-1:0];
				REG_SIZE_Y:      size_y_q <= wr_data[DIM_W-1:0];
				REG_SIZE_Z:      size_z_q <= wr_data[DIM_W-1:0];
				REG_BURST_LIMIT: burst_q  <= wr_data[BURST_W-1:0];
				REG_VOXEL_COLOR: color_q  <= wr_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		xy_s1  <= {{DIM_W{1'b0}}, eff_x} * {{DIM_W{1'b0}}, eff_y};
		vol_s2 <= {{DIM_W{1'b0}}, xy_s1} * {{(2*DIM_W){1'b0}}, eff_z};
		if (cmd.capture) begin
			command_q <= pair_data.command;
			value_q   <= pair_data.run_value;
			count_q   <= pair_data.run_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q    <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			cur_z_q   <= '0;
			pending_q <= '0;
		end else begin
			if (cmd.eval && decision == DEC_BURST) begin
				pending_q <= need - take;
			end
			if (advance) begin
				cell_q <= cell_q + VOL_W'(1);
				if (y_inc >= eff_y) begin
					cur_y_q <= '0;
					if (z_inc >= eff_z) begin
						cur_z_q <= '0;
						cur_x_q <= cur_x_q + DIM_W'(1);
					end else begin
						cur_z_q <= z_inc;
					end
				end else begin
					cur_y_q <= y_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			case (decision)
				DEC_BURST: cnt_q        <= take;
				DEC_SKIP:  cnt_q        <= count_q;
				DEC_FAULT: fault_kind_q <= fault_kind;
				default: ;
			endcase
		end else if (advance) begin
			cnt_q <= cnt_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_voxel || cmd.emit_fault) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_voxel) begin
			out_data_q.kind      <= KIND_VOXEL;
			out_data_q.pos_x     <= cur_x_q[POS_W-1:0];
			out_data_q.pos_y     <= cur_y_q[POS_W-1:0];
			out_data_q.pos_z     <= cur_z_q[POS_W-1:0];
			out_data_q.color     <= color_q;
			out_data_q.last      <= (cnt_q == COUNT_W'(1));
			out_data_q.remaining <= pending_q;
		end else if (cmd.emit_fault) begin
			out_data_q.kind      <= fault_kind_q;
			out_data_q.pos_x     <= '0;
			out_data_q.pos_y     <= '0;
			out_data_q.pos_z     <= '0;
			out_data_q.color     <= '0;
			out_data_q.last      <= 1'b1;
			out_data_q.remaining <= pending_q;
		end
	end

	assign status.decision = decision;
	assign status.out_free = out_free;
	assign status.cnt_one  = (cnt_q == COUNT_W'(1));
	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;

endmodule

`default_nettype wire

// File: sv/voxel_run_length_decoder.sv
// Flow: a pair transfers, then passes two volume product stages, a check
// state and a result register load before its result shows.
// A new pair is taken only once the previous one is done. A filled run or
// a continue gives one voxel per cycle from the cell counters, held by any
// output stall; an empty run steps the cell counters without results.
// Reset: FSM, config, counters, output valid clear; burst_limit goes to 64.
// ----------------------------------------------------------------------------
// voxel_run_length_decoder
// Run-length voxel stream decoder over a configurable y-z-x grid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_run_length_decoder_assert.svh"

module voxel_run_length_decoder #(
	parameter int unsigned MAX_DIM   = 4096,
	parameter int unsigned MAX_BURST = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	vrld_pair_if.sink                            pairs,
	vrld_voxel_if.source                         voxels,
	input  wire logic                            wr_en,
	input  wire logic [vrld_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [vrld_pkg::CFG_DATA_W-1:0] wr_data
);
	import vrld_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       pair_ready;

	vrld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pairs.valid),
		.pair_ready (pair_ready),
		.status     (status),
		.cmd        (cmd)
	);

	vrld_dp #(
		.MAX_DIM   (MAX_DIM),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.pair_data (pairs.data),
		.cmd       (cmd),
		.status    (status),
		.out_ready (voxels.ready),
		.out_valid (voxels.valid),
		.out_data  (voxels.data)
	);

	assign pairs.ready = pair_ready;

	`VRLD_ASSERT_NXT(a_one_pair_at_a_time, pairs.valid && pairs.ready, !pairs.ready,
		"pair taken while previous pair still in work")
	`VRLD_ASSERT_IMP(a_fault_is_last, voxels.valid && voxels.data.kind != KIND_VOXEL,
		voxels.data.last, "fault result without last")
	`VRLD_ASSERT_IMP(a_fault_zero_fields, voxels.valid && voxels.data.kind != KIND_VOXEL,
		voxels.data.pos_x == '0 && voxels.data.pos_y == '0 &&
		voxels.data.pos_z == '0 && voxels.data.color == '0,
		"fault result with nonzero coordinates or color")

endmodule

`default_nettype wire

// File: tb/voxel_run_length_decoder_test.sv
// ----------------------------------------------------------------------------
// voxel_run_length_decoder_test
// Self-checking bench for the voxel run decoder. A short directed part covers
// the empty volume after reset, busy, bad value, run beyond volume and end of
// data, zero-count runs, clamped extents and burst limits, and the top x
// coordinate. Random phases then vary grid, burst limit and colour along with
// handshake pacing. A behavioral decoder predicts every result transfer;
// results are compared field by field in arrival order.
// ----------------------------------------------------------------------------

module voxel_run_length_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vrld_pkg::*;

	localparam int unsigned DIM_LIMIT = 4096;
	localparam int unsigned BURST_CAP = 64;
	localparam int SETTLE_CYCLES = 300;
	localparam int LONG_HOLD = 600;
	localparam int unsigned RANDOM_ITEMS = 220;

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	vrld_pair_if pairs_if ();
	vrld_voxel_if voxels_if ();

	voxel_run_length_decoder #(
		.MAX_DIM(DIM_LIMIT),
		.MAX_BURST(BURST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pairs(pairs_if),
		.voxels(voxels_if),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// register shadow
	logic [DIM_W-1:0] dim_x = '0;
	logic [DIM_W-1:0] dim_y = '0;
	logic [DIM_W-1:0] dim_z = '0;
	logic [BURST_W-1:0] burst_reg = BURST_RESET;
	logic [COLOR_W-1:0] color_reg = '0;

	// decoder state
	longint unsigned cell_at = 0;
	int unsigned at_x = 0;
	int unsigned at_y = 0;
	int unsigned at_z = 0;
	int unsigned run_left = 0;

	pair_item_t runs_to_send[$];
	voxel_item_t voxels_due[$];
	int failures = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_left = 0;
	logic hold_start = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned dim_eff(logic [DIM_W-1:0] d);
		return (d > DIM_LIMIT) ? DIM_LIMIT : d;
	endfunction

	function automatic int unsigned burst_eff();
		if (burst_reg == 0) begin
			return 1;
		end
		return (burst_reg > BURST_CAP) ? BURST_CAP : burst_reg;
	endfunction

	// y fastest, then z, then x
	function automatic void step_cell();
		cell_at++;
		at_y++;
		if (at_y >= dim_eff(dim_y)) begin
			at_y = 0;
			at_z++;
			if (at_z >= dim_eff(dim_z)) begin
				at_z = 0;
				at_x++;
			end
		end
	endfunction

	function automatic void push_fault(logic [KIND_W-1:0] kind);
		voxel_item_t r;
		r = '0;
		r.kind = kind;
		r.last = 1'b1;
		r.remaining = COUNT_W'(run_left);
		voxels_due.push_back(r);
	endfunction

	function automatic void emit_burst(int unsigned cells);
		int unsigned take;
		voxel_item_t r;
		take = (cells < burst_eff()) ? cells : burst_eff();
		run_left = cells - take;
		for (int unsigned i = 0; i < take; i++) begin
			r.kind = KIND_VOXEL;
			r.pos_x = POS_W'(at_x);
			r.pos_y = POS_W'(at_y);
			r.pos_z = POS_W'(at_z);
			r.color = color_reg;
			r.last = (i + 1 == take);
			r.remaining = COUNT_W'(run_left);
			voxels_due.push_back(r);
			step_cell();
		end
	endfunction

	function automatic void decode_run(pair_item_t p);
		longint unsigned vol;
		vol = 64'(dim_eff(dim_x)) * 64'(dim_eff(dim_y)) * 64'(dim_eff(dim_z));
		if (p.command == CMD_CONTINUE) begin
			if (run_left != 0) begin
				emit_burst(run_left);
			end
		end else if (run_left != 0) begin
			push_fault(KIND_BUSY);
		end else if (cell_at >= vol) begin
			push_fault(KIND_END);
		end else if (cell_at + p.run_count > vol) begin
			push_fault(KIND_BEYOND);
		end else if (p.run_value == VALUE_EMPTY) begin
			repeat (p.run_count) step_cell();
		end else if (p.run_value == VALUE_FILLED) begin
			emit_burst(p.run_count);
		end else begin
			push_fault(KIND_BADVAL);
		end
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	function automatic void check_voxel(voxel_item_t got);
		voxel_item_t want;
		if (voxels_due.size() == 0) begin
			$error("unexpected result transfer, kind %0d", got.kind);
			failures++;
			return;
		end
		want = voxels_due.pop_front();
		check_field("kind", want.kind, got.kind);
		check_field("pos_x", want.pos_x, got.pos_x);
		check_field("pos_y", want.pos_y, got.pos_y);
		check_field("pos_z", want.pos_z, got.pos_z);
		check_field("color", want.color, got.color);
		check_field("last", want.last, got.last);
		check_field("remaining", want.remaining, got.remaining);
	endfunction

	// driver: prediction happens at the transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_if.valid <= 1'b0;
			pairs_if.data <= '0;
		end else begin
			if (pairs_if.valid && pairs_if.ready) begin
				decode_run(pairs_if.data);
			end
			if (!pairs_if.valid || pairs_if.ready) begin
				if (runs_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					pairs_if.valid <= 1'b1;
					pairs_if.data <= runs_to_send.pop_front();
				end else begin
					pairs_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voxels_if.ready <= 1'b0;
		end else begin
			if (voxels_if.valid && voxels_if.ready) begin
				check_voxel(voxels_if.data);
			end
			voxels_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_start) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	function automatic void set_pace(pace_t pace);
		case (pace)
			PACE_FULL: begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end
			PACE_SRC_IDLE: begin
				src_idle_pct = 68;
				snk_stall_pct = 0;
			end
			PACE_SNK_STALL: begin
				src_idle_pct = 0;
				snk_stall_pct = 68;
			end
			default: begin
				src_idle_pct = 31;
				snk_stall_pct = 31;
			end
		endcase
	endfunction

	function automatic void send(logic cmd, logic [COUNT_W-1:0] value,
			logic [COUNT_W-1:0] count);
		pair_item_t p;
		p.command = cmd;
		p.run_value = value;
		p.run_count = count;
		runs_to_send.push_back(p);
	endfunction

	// filled run plus the continues that drain it; optionally a pair cuts in
	function automatic int unsigned send_filled(logic [COUNT_W-1:0] count, bit cut_in);
		int unsigned tail;
		tail = (count == 0) ? 0 : (count - 1) / burst_eff();
		send(CMD_PAIR, VALUE_FILLED, count);
		if (cut_in) begin
			send(CMD_PAIR, COUNT_W'($urandom_range(2)), COUNT_W'($urandom));
		end
		repeat (tail) send(CMD_CONTINUE, COUNT_W'($urandom), COUNT_W'($urandom));
		return tail + 1 + cut_in;
	endfunction

	function automatic void add_random_items(int unsigned quota, inout int unsigned made);
		int unsigned pick;
		int unsigned goal;
		logic [COUNT_W-1:0] count;
		goal = made + quota;
		while (made < goal) begin
			pick = $urandom_range(99);
			count = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(8)) : COUNT_W'($urandom);
			if (pick < 45) begin
				made += send_filled(count, 1'b0);
			end else if (pick < 72) begin
				send(CMD_PAIR, VALUE_EMPTY, count);
				made++;
			end else if (pick < 80) begin
				send(CMD_PAIR, COUNT_W'($urandom_range(255, 2)), count);
				made++;
			end else if (pick < 86) begin
				send(CMD_CONTINUE, COUNT_W'($urandom), count);
			end else if (pick < 93) begin
				made += send_filled(count, 1'b1);
			end else begin
				send(1'($urandom), COUNT_W'($urandom), count);
				made++;
			end
		end
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned pick;
		pick = $urandom_range(31);
		if (pick == 0) begin
			return '0;
		end
		if (pick < 4) begin
			return DIM_W'(1);
		end
		if (pick < 20) begin
			return DIM_W'($urandom_range(40, 2));
		end
		if (pick < 26) begin
			return DIM_W'($urandom_range(200, 41));
		end
		if (pick < 30) begin
			return DIM_W'(DIM_LIMIT);
		end
		return DIM_W'($urandom_range(DIM_MAX_CODE, DIM_LIMIT + 1));
	endfunction

	function automatic logic [BURST_W-1:0] pick_burst();
		case ($urandom_range(7))
			0: return '0;
			1: return BURST_W'(1);
			2: return BURST_W'(BURST_CAP);
			3: return '1;
			4: return BURST_W'($urandom_range(127, 65));
			default: return BURST_W'($urandom_range(BURST_CAP, 2));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx,
			input logic [CFG_DATA_W-1:0] value, input int width);
		logic [CFG_DATA_W-1:0] word;
		word = value;
		if (width < CFG_DATA_W) begin
			word = word | ($urandom << width);
		end
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= reg_idx;
		wr_data <= word;
		@(posedge clk);
		wr_en <= 1'b0;
		case (reg_idx)
			REG_SIZE_X: dim_x = word[DIM_W-1:0];
			REG_SIZE_Y: dim_y = word[DIM_W-1:0];
			REG_SIZE_Z: dim_z = word[DIM_W-1:0];
			REG_BURST_LIMIT: burst_reg = word[BURST_W-1:0];
			REG_VOXEL_COLOR: color_reg = word[COLOR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [DIM_W-1:0] sx, input logic [DIM_W-1:0] sy,
			input logic [DIM_W-1:0] sz, input logic [BURST_W-1:0] burst,
			input logic [COLOR_W-1:0] color);
		write_reg(REG_SIZE_X, sx, DIM_W);
		write_reg(REG_SIZE_Y, sy, DIM_W);
		write_reg(REG_SIZE_Z, sz, DIM_W);
		write_reg(REG_BURST_LIMIT, burst, BURST_W);
		write_reg(REG_VOXEL_COLOR, color, COLOR_W);
	endtask

	// all transfers done, then room for a trailing skip run to finish
	task automatic wait_drained();
		@(negedge clk);
		while (runs_to_send.size() != 0 || pairs_if.valid || voxels_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned made;
		int unsigned phase;
		made = 0;
		phase = 0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero extents after reset: run pairs hit end of data, the continue is a no-op
		@(negedge clk);
		set_pace(PACE_BOTH);
		send(CMD_PAIR, VALUE_FILLED, 8'd5);
		send(CMD_CONTINUE, 8'hFF, 8'hFF);
		send(CMD_PAIR, 8'hFF, 8'hFF);
		wait_drained();

		// 2x3x2 grid, burst limit 0 acts as 1
		configure(13'd2, 13'd3, 13'd2, 7'd0, 32'hFFFF_FFFF);
		@(negedge clk);
		set_pace(PACE_SNK_STALL);
		send(CMD_PAIR, VALUE_FILLED, 8'd3);
		send(CMD_PAIR, VALUE_EMPTY, 8'd2);
		send(CMD_CONTINUE, 8'd0, 8'd0);
		send(CMD_CONTINUE, 8'd0, 8'd0);
		send(CMD_CONTINUE, 8'd0, 8'd0);
		send(CMD_PAIR, VALUE_EMPTY, 8'd0);
		send(CMD_PAIR, VALUE_FILLED, 8'd0);
		send(CMD_PAIR, VALUE_EMPTY, 8'd4);
		send(CMD_PAIR, 8'hFF, 8'd1);
		send(CMD_PAIR, 8'd2, 8'd0);
		send(CMD_PAIR, VALUE_FILLED, 8'd6);
		void'(send_filled(8'd5, 1'b0));
		send(CMD_PAIR, VALUE_EMPTY, 8'd0);
		wait_drained();

		// clamped x extent, burst above cap; walk x up to its top value
		configure(DIM_W'(DIM_MAX_CODE), 13'd1, 13'd1, '1, $urandom);
		@(negedge clk);
		set_pace(PACE_SRC_IDLE);
		repeat (16) send(CMD_PAIR, VALUE_EMPTY, 8'd255);
		send(CMD_PAIR, VALUE_FILLED, 8'd15);
		send(CMD_PAIR, VALUE_FILLED, 8'd255);
		send(CMD_PAIR, VALUE_FILLED, 8'd1);
		send(CMD_PAIR, VALUE_EMPTY, 8'd0);
		wait_drained();

		// backpressure: receiver holds off while long runs queue up
		configure(13'd40, 13'd40, 13'd40, BURST_W'(BURST_CAP), $urandom);
		@(negedge clk);
		set_pace(PACE_FULL);
		hold_start = 1'b1;
		repeat (10) made += send_filled(COUNT_W'($urandom_range(255, 128)), 1'b0);
		@(negedge clk);
		hold_start = 1'b0;
		wait_drained();

		while (made < RANDOM_ITEMS) begin
			configure(pick_dim(), pick_dim(), pick_dim(), pick_burst(), $urandom);
			@(negedge clk);
			set_pace(pace_t'(phase % 4));
			add_random_items(30 + $urandom_range(15), made);
			wait_drained();
			phase++;
		end

		if (failures == 0 && voxels_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
